/* src/cng_pkg.sv */
// Shared types, constants and helpers for the colored noise generator.
// No dependencies; imported by cng_mul, colored_noise_generator and tb_top.
package cng_pkg;

	// Operand widths of the shared serial multiplier
	localparam int MulAW    = 36;              // multiplicand, signed
	localparam int MulBW    = 36;              // multiplier, signed, whole digits
	localparam int DigitW   = 4;
	localparam int NumDigit = MulBW / DigitW;
	localparam int ProdW    = 72;
	localparam int RndW     = ProdW - 30;      // product rounded by 2^-30

	typedef logic signed [33:0] coef_t;        // Q.30 coefficient, signed

	// LCG constants
	localparam logic [31:0] LcgMul = 32'd435898247;
	localparam logic [31:0] LcgAdd = 32'd382842987;

	// Pink sections: pole and feed coefficients
	localparam coef_t PoleCoef [6] = '{
		34'sd1072517758, 34'sd1066569229, 34'sd1040455827,
		34'sd930397290,  34'sd590558003,  -34'sd817761773
	};
	localparam coef_t FeedCoef [6] = '{
		34'sd59611891,  34'sd80612134,  34'sd165197327,
		34'sd333381374, 34'sd572253077, -34'sd18144089
	};
	localparam coef_t PinkDirect = 34'sd575740366;
	localparam coef_t PinkGain   = 34'sd118111601;
	localparam coef_t PinkDelay  = 34'sd124474595;
	localparam coef_t BrownKeep  = 34'sd1052688063;
	localparam coef_t BrownFeed  = 34'sd21053761;
	localparam coef_t BrownGain  = 34'sd3758096384;
	localparam coef_t LcgMulCoef = 34'sd435898247;

	// Configuration register indexes
	localparam logic RegColor = 1'b0;
	localparam logic RegSeed  = 1'b1;

	// Color codes
	localparam logic [1:0] ColorWhite = 2'd0;
	localparam logic [1:0] ColorPink  = 2'd1;
	localparam logic [1:0] ColorBrown = 2'd2;
	localparam logic [1:0] ColorNone  = 2'd3;

	// Saturate a rounded sum to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [RndW:0] x);
		logic signed [RndW:0] hi;
		logic signed [RndW:0] lo;
		hi = (RndW+1)'(32'sh7fffffff);
		lo = -hi - (RndW+1)'(1);
		if (x > hi)
			return 32'sh7fffffff;
		else if (x < lo)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

endpackage

/* src/cng_mul.sv */
// Digit-serial signed multiplier, four multiplier bits per cycle, MSB first.
// Depends on cng_pkg.
module cng_mul
	import cng_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [MulAW-1:0]   a,
	input  logic signed [MulBW-1:0]   b,
	output logic                      done,
	output logic signed [ProdW-1:0]   prod
);

	localparam int CntW = $clog2(NumDigit + 1);

	logic signed [MulAW-1:0] a_q;
	logic        [MulBW-1:0] b_q;       // digits shift out at the top
	logic signed [ProdW-1:0] acc_q;
	logic        [CntW-1:0]  cnt_q;
	logic                    busy_q;
	logic                    first_q;
	logic                    done_q;

	logic signed [DigitW:0]       dig;
	logic signed [MulAW+DigitW:0] pp;
	logic signed [ProdW-1:0]      acc_next;

	// top digit is signed, the rest unsigned
	always_comb begin
		if (first_q)
			dig = {b_q[MulBW-1], b_q[MulBW-1 -: DigitW]};
		else
			dig = {1'b0, b_q[MulBW-1 -: DigitW]};
		pp       = a_q * dig;
		acc_next = (acc_q <<< DigitW) +
			{{(ProdW-MulAW-DigitW-1){pp[MulAW+DigitW]}}, pp};
	end

	// Horner accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= CntW'(NumDigit);
				a_q     <= a;
				b_q     <= b;
				acc_q   <= '0;
			end else if (busy_q) begin
				acc_q   <= acc_next;
				b_q     <= b_q << DigitW;
				first_q <= 1'b0;
				cnt_q   <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	a_no_restart : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("multiplier started while busy");
	a_done_once : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("multiplier done held");
	a_busy_drop : assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q) else $error("busy dropped without done");

endmodule

/* src/colored_noise_generator.sv */
// Colored noise generator: LCG white source, pink filter bank, brown integrator.
// Depends on cng_pkg and cng_mul.
//
// One input transfer is one sample tick and yields one output transfer. All
// products go through one digit-serial multiplier. A product passes through
// the issue state, one digit step per multiplier digit and the wait state in
// which the product is taken. Besides the accept and output states, an item
// makes one product in white mode (the generator advance), four in brown mode
// and sixteen in pink mode (each including the generator advance). An
// inactive tick or color 3 goes from the accept state straight to the output
// state without a product. The result waits in the output stage while the
// output register still holds an untaken sample, and a new item is taken
// only once the previous result has been loaded into the output register.
module colored_noise_generator
	import cng_pkg::*;
#(
	parameter int STATE_FRAC_BITS = 30,
	parameter int OUT_WIDTH       = 24
)
(
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [31:0]                   cfg_wdata,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,    // [0] active, [1] restart
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [((OUT_WIDTH+7)/8)*8-1:0] m_tdata    // sample, signed
);

	localparam int OutFrac = OUT_WIDTH - 4;
	localparam int Sh      = STATE_FRAC_BITS - OutFrac;
	localparam int ShR     = (Sh > 0) ? Sh : 0;
	localparam int ShL     = (Sh < 0) ? -Sh : 0;
	localparam int VW      = 56;
	localparam int TdW     = ((OUT_WIDTH + 7) / 8) * 8;
	localparam logic signed [VW-1:0] Rnd = (ShR > 0) ? (VW'(1) <<< (ShR - 1)) : '0;
	localparam logic signed [VW-1:0] OutHi = (VW'(1) <<< (OUT_WIDTH - 1)) - VW'(1);
	localparam logic signed [VW-1:0] OutLo = -OutHi - VW'(1);

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_t;

	state_t                   state_q;
	logic [1:0]               color_q;
	logic [31:0]              seed_start_q;
	logic [31:0]              seed_q;
	logic signed [31:0]       pink_q [7];
	logic signed [31:0]       brown_q;
	logic signed [31:0]       w_q;
	logic signed [RndW-1:0]   t_q;
	logic signed [MulAW-1:0]  sum_q;
	logic signed [39:0]       y_q;
	logic [3:0]               step_q;
	logic                     m_tvalid_q;
	logic [TdW-1:0]           m_tdata_q;

	logic                     active;
	logic                     restart;
	logic [31:0]              seed_eff;
	logic [30:0]              u;
	logic signed [31:0]       w_new;
	logic                     mul_start;
	logic signed [MulAW-1:0]  mul_a;
	logic signed [MulBW-1:0]  mul_b;
	logic                     mul_done;
	logic signed [ProdW-1:0]  prod;
	logic signed [ProdW-1:0]  prod_rnd;
	logic signed [RndW-1:0]   r;
	logic signed [31:0]       sat_new;
	logic [2:0]               sec;
	logic                     last_step;
	logic signed [VW-1:0]     v;
	logic signed [VW-1:0]     v_sat;
	logic                     out_load;

	assign active  = s_tdata[0];
	assign restart = s_tdata[1];

	// white sample from the seed in effect for this tick
	assign seed_eff = restart ? seed_start_q : seed_q;
	assign u        = seed_eff[30:0];
	assign w_new    = 32'(u >> (30 - STATE_FRAC_BITS)) - (32'sd1 <<< STATE_FRAC_BITS);

	// rounded product, Q.30 coefficient removed
	assign prod_rnd = prod + (ProdW'(1) <<< 29);
	assign r        = prod_rnd[ProdW-1:30];
	assign sat_new  = sat32((RndW+1)'(t_q) + (RndW+1)'(r));
	assign sec      = step_q[3:1];

	// operand select per mode and step
	always_comb begin
		mul_a     = {4'b0, seed_q};
		mul_b     = MulBW'(LcgMulCoef);
		last_step = 1'b1;
		case (color_q)
			ColorPink: begin
				last_step = (step_q == 4'd15);
				if (step_q < 4'd12) begin
					if (!step_q[0]) begin
						mul_a = MulAW'(pink_q[sec]);
						mul_b = MulBW'(PoleCoef[sec]);
					end else begin
						mul_a = MulAW'(w_q);
						mul_b = MulBW'(FeedCoef[sec]);
					end
				end else if (step_q == 4'd12) begin
					mul_a = MulAW'(w_q);
					mul_b = MulBW'(PinkDirect);
				end else if (step_q == 4'd13) begin
					mul_a = sum_q;
					mul_b = MulBW'(PinkGain);
				end else if (step_q == 4'd14) begin
					mul_a = MulAW'(w_q);
					mul_b = MulBW'(PinkDelay);
				end
			end
			ColorBrown: begin
				last_step = (step_q == 4'd3);
				case (step_q)
					4'd0: begin
						mul_a = MulAW'(brown_q);
						mul_b = MulBW'(BrownKeep);
					end
					4'd1: begin
						mul_a = MulAW'(w_q);
						mul_b = MulBW'(BrownFeed);
					end
					4'd2: begin
						mul_a = MulAW'(brown_q);
						mul_b = MulBW'(BrownGain);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign mul_start = (state_q == ST_ISSUE);

	cng_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	// output scaling and saturation
	always_comb begin
		v = ((VW'(y_q) + Rnd) >>> ShR) <<< ShL;
		if (v > OutHi)
			v_sat = OutHi;
		else if (v < OutLo)
			v_sat = OutLo;
		else
			v_sat = v;
	end

	// result enters the output register when it is empty or being taken
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// sequencer, filter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			color_q      <= ColorWhite;
			seed_start_q <= '0;
			seed_q       <= '0;
			for (int i = 0; i < 7; i++)
				pink_q[i] <= '0;
			brown_q      <= '0;
			step_q       <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					RegColor: color_q      <= cfg_wdata[1:0];
					RegSeed:  seed_start_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						step_q <= '0;
						seed_q <= seed_eff;
						w_q    <= w_new;
						if (restart) begin
							for (int i = 0; i < 7; i++)
								pink_q[i] <= '0;
							brown_q <= '0;
							sum_q   <= '0;
						end else begin
							sum_q <= MulAW'(pink_q[6]);
						end
						if (!active || color_q == ColorNone) begin
							y_q     <= '0;
							state_q <= ST_OUT;
						end else begin
							y_q     <= 40'(w_new);
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mul_done) begin
						if (last_step) begin
							seed_q  <= prod[31:0] + LcgAdd;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_ISSUE;
							step_q  <= step_q + 4'd1;
						end
						if (color_q == ColorPink) begin
							if (step_q < 4'd12) begin
								if (!step_q[0]) begin
									t_q <= r;
								end else begin
									pink_q[sec] <= sat_new;
									sum_q       <= sum_q + MulAW'(sat_new);
								end
							end else if (step_q == 4'd12) begin
								sum_q <= sum_q + MulAW'(r);
							end else if (step_q == 4'd13) begin
								y_q <= 40'(r);
							end else if (step_q == 4'd14) begin
								pink_q[6] <= sat32((RndW+1)'(r));
							end
						end else if (color_q == ColorBrown) begin
							case (step_q)
								4'd0: t_q     <= r;
								4'd1: brown_q <= sat_new;
								4'd2: y_q     <= 40'(r);
								default: ;
							endcase
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_tdata_q <= TdW'(v_sat[OUT_WIDTH-1:0]);
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_one_item : assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second item taken while busy");
	a_done_in_wait : assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_WAIT) else $error("product arrived outside wait");
	a_load_from_out : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT)) else $error("result loaded early");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for colored_noise_generator: random ticks and restarts across
// colors, results checked against an in-bench fixed-point noise predictor.
// Depends on cng_pkg and the colored_noise_generator RTL.
module tb_top
	import cng_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OutW = 24;
	localparam int OutFrac = OutW - 4;
	localparam int FracB = 30;
	localparam int WatchLimit = 20000;
	localparam int HoldCycles = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_addr = RegColor;
	logic [31:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;

	colored_noise_generator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [1:0] color_q;
	logic [31:0] seed_cfg;
	logic [31:0] lcg_seed;
	longint pink_st [7];
	longint brown_st;

	logic [23:0] sample_q [$];
	logic [7:0] tick_q [$];
	int errors = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	function automatic longint rnd_mul(longint x, longint c);
		longint p;
		p = x * c + (64'sd1 <<< 29);
		return p >>> 30;
	endfunction

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// advance the noise model by one tick and return the expected sample
	function automatic logic [23:0] noise_tick(logic [7:0] t);
		longint w, y, acc, v;
		if (t[1]) begin
			lcg_seed = seed_cfg;
			foreach (pink_st[i]) pink_st[i] = 0;
			brown_st = 0;
		end
		if (!t[0] || color_q == ColorNone) return '0;
		w = longint'({1'b0, lcg_seed[30:0]}) - (64'sd1 <<< FracB);
		lcg_seed = lcg_seed * LcgMul + LcgAdd;
		y = w;
		if (color_q == ColorPink) begin
			acc = 0;
			for (int i = 0; i < 6; i++) begin
				pink_st[i] = clip32(rnd_mul(pink_st[i], longint'(PoleCoef[i]))
					+ rnd_mul(w, longint'(FeedCoef[i])));
				acc += pink_st[i];
			end
			acc += pink_st[6] + rnd_mul(w, longint'(PinkDirect));
			y = rnd_mul(acc, longint'(PinkGain));
			pink_st[6] = clip32(rnd_mul(w, longint'(PinkDelay)));
		end else if (color_q == ColorBrown) begin
			brown_st = clip32(rnd_mul(brown_st, longint'(BrownKeep))
				+ rnd_mul(w, longint'(BrownFeed)));
			y = rnd_mul(brown_st, longint'(BrownGain));
		end
		v = (y + (64'sd1 <<< (FracB - OutFrac - 1))) >>> (FracB - OutFrac);
		if (v > 64'sd8388607) v = 64'sd8388607;
		if (v < -64'sd8388608) v = -64'sd8388608;
		return v[23:0];
	endfunction

	// driver: offer queued ticks with random gaps
	int tx_gap = 0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_q = {sample_q, noise_tick(s_tdata)};
			void'(tick_q.pop_front());
		end
		if (s_tvalid && !s_tready) begin
			// hold current transfer
		end else if (tx_gap > 0) begin
			tx_gap <= tx_gap - 1;
			s_tvalid <= 1'b0;
		end else if (tick_q.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tdata <= tick_q[0];
			if ($urandom_range(0, 3) == 0)
				tx_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
					: $urandom_range(1, 3);
		end else
			s_tvalid <= 1'b0;
	end

	// monitor: random back-pressure, one long hold on request, compare each sample
	int rx_gap = 0;
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (sample_q.size() == 0) begin
				$error("unexpected sample transfer 0x%h", m_tdata);
				errors++;
			end else begin
				if (m_tdata !== sample_q[0]) begin
					$error("sample: expected 0x%h, got 0x%h", sample_q[0], m_tdata);
					errors++;
				end
				void'(sample_q.pop_front());
			end
		end
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HoldCycles;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				rx_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200)
					: $urandom_range(1, 3);
		end
	end

	// watchdog on cycles without any transfer
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("[colored_noise_generator] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegColor) color_q = val[1:0];
		else seed_cfg = val;
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || s_tvalid || sample_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// mostly active ticks, occasional restarts
	task automatic queue_ticks(int n);
		logic [7:0] t;
		for (int i = 0; i < n; i++) begin
			t = '0;
			t[0] = ($urandom_range(0, 9) != 0);
			t[1] = ($urandom_range(0, 39) == 0);
			tick_q = {tick_q, t};
		end
	endtask

	logic [31:0] seeds [4] = '{32'h0, 32'hffffffff, 32'h7fffffff, 32'h80000000};

	initial begin
		color_q = ColorWhite;
		seed_cfg = '0;
		lcg_seed = '0;
		foreach (pink_st[i]) pink_st[i] = 0;
		brown_st = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: all colors, extreme seeds, restart while idle, color 3
		for (int c = 0; c < 4; c++) begin
			write_reg(RegColor, 32'(c));
			write_reg(RegSeed, seeds[c]);
			tick_q = {tick_q, 8'h02, 8'h01, 8'h03, 8'h00, 8'h01, 8'h01};
			wait_drained();
		end

		// receiver holds off long while the sender keeps offering
		write_reg(RegColor, 32'(ColorWhite));
		hold_req = 1'b1;
		wait (hold_done);
		queue_ticks(40);
		wait (hold_left == 0);
		wait_drained();

		// random phases across colors and seeds
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(RegColor, (ph % 4 == 3) ? 32'(ColorNone) : 32'($urandom_range(0, 2)));
			write_reg(RegSeed, $urandom());
			tick_q = {tick_q, 8'h03};
			queue_ticks(ph % 3 == 0 ? 260 : 95);
			wait_drained();
		end

		if (errors == 0) $display("[colored_noise_generator] OK");
		else $display("[colored_noise_generator] ERROR");
		$finish;
	end
endmodule

/* sim.f */
src/cng_pkg.sv
src/cng_mul.sv
src/colored_noise_generator.sv
tb/tb_top.sv
